// ===== hdl/mavg_pkg.sv =====
package mavg_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 24;
    localparam int SUM_W    = 24;
    localparam int WIN_W    = 8;
    localparam int FRAC_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_START_VALUE = 2'd1
    } cfg_reg_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_INIT = 4'b1000
    } state_t;

    // Divider status towards the controller
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== hdl/moving_average_filter_top.sv =====
// Moving average filter over a ring of the last window_size samples.
//
// Channels: the input request carries one signed 16-bit sample (in_valid /
// in_ready). Each accepted sample replaces the oldest ring entry and yields
// one output request (out_valid / out_ready) carrying the window mean as
// signed fixed point with 8 fraction bits, truncated toward zero, and the
// sample itself. Configuration writes (cfg_valid / cfg_ready, cfg_index,
// cfg_data) set window_size (index 0) or start_value (index 1) and restart
// the window: every entry reads as start_value and the head returns to 0.
//
// Timing: the ring entry at the head is read at acceptance and written back
// in the next cycle, when a bit-serial division of the sum starts; a new
// sample is taken only after the result has been loaded into the output
// register. That register lets the next sample enter while a result waits;
// a stalled receiver holds the block only once a second result is finished.
// A configuration write passes through ST_INIT before the block is idle.
//
// Reset: window_size 16, start_value 0, running sum 0, head 0; ring entries
// not written since the last restart read as start_value, so no clearing
// pass is needed.
module moving_average_filter_top
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW = 255
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_W-1:0]   sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [AVG_W-1:0]      average,
    output logic signed [SAMPLE_W-1:0]   latest_sample,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam logic [WIN_W:0] MAX_N = (WIN_W + 1)'(MAX_WINDOW);

    state_t                      state_reg, state_next;
    logic [WIN_W-1:0]            window_size_reg, window_size_next;
    logic signed [SAMPLE_W-1:0]  start_value_reg, start_value_next;
    logic [PTR_W-1:0]            head_reg, head_next;
    logic                        wrapped_reg, wrapped_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic                        out_valid_reg, out_valid_next;
    logic signed [AVG_W-1:0]     average_reg;
    logic signed [SAMPLE_W-1:0]  latest_sample_reg;

    logic [WIN_W-1:0]            eff_n;
    logic                        in_fire;
    logic                        cfg_fire;
    logic                        head_wrap;
    logic [SAMPLE_W-1:0]         rd_data;
    logic signed [SAMPLE_W-1:0]  old_entry;
    logic signed [SUM_W-1:0]     sum_upd;
    logic signed [SUM_W-1:0]     init_sum;
    logic                        div_start;
    logic signed [AVG_W-1:0]     div_quo;
    div_stat_t                   div_stat;
    logic                        out_load;

    // Effective window length: zero counts as one, clamp to the ring depth
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            eff_n = WIN_W'(1);
        end
        else if ({1'b0, window_size_reg} > MAX_N)
        begin
            eff_n = MAX_N[WIN_W-1:0];
        end
        else
        begin
            eff_n = window_size_reg;
        end
    end

    // Handshakes
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    // Ring memory: read at the head on acceptance, write back in the following cycle
    mavg_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (PTR_W)
    ) u_ring (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (head_reg),
        .rd_data (rd_data),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (head_reg),
        .wr_data (sample_reg)
    );

    // Entries not yet written since the last restart hold start_value
    assign old_entry = wrapped_reg ? $signed(rd_data) : start_value_reg;
    assign sum_upd   = sum_reg - SUM_W'(old_entry) + SUM_W'(sample_reg);
    assign init_sum  = SUM_W'(start_value_reg) * SUM_W'($signed({1'b0, eff_n}));
    assign head_wrap = (32'(head_reg) + 32'd1 >= 32'(eff_n));

    // Mean of the window
    assign div_start = (state_reg == ST_READ);

    mavg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_upd),
        .den   (eff_n),
        .quo   (div_quo),
        .stat  (div_stat)
    );

    assign out_load = (state_reg == ST_DIV) && div_stat.done && (!out_valid_reg || out_ready);

    // Sequencer and window bookkeeping
    always_comb
    begin
        state_next       = state_reg;
        window_size_next = window_size_reg;
        start_value_next = start_value_reg;
        head_next        = head_reg;
        wrapped_next     = wrapped_reg;
        sum_next         = sum_reg;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    case (cfg_index)
                        REG_WINDOW_SIZE:
                        begin
                            window_size_next = cfg_data[WIN_W-1:0];
                            state_next       = ST_INIT;
                        end
                        REG_START_VALUE:
                        begin
                            start_value_next = $signed(cfg_data[SAMPLE_W-1:0]);
                            state_next       = ST_INIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
                else if (in_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                sum_next = sum_upd;
                if (head_wrap)
                begin
                    head_next    = '0;
                    wrapped_next = 1'b1;
                end
                else
                begin
                    head_next = head_reg + PTR_W'(1);
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                sum_next     = init_sum;
                head_next    = '0;
                wrapped_next = 1'b0;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= WIN_W'(16);
            start_value_reg <= '0;
            head_reg        <= '0;
            wrapped_reg     <= 1'b0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_size_reg <= window_size_next;
            start_value_reg <= start_value_next;
            head_reg        <= head_next;
            wrapped_reg     <= wrapped_next;
            sum_reg         <= sum_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sample_reg <= sample;
        end
        if (out_load)
        begin
            average_reg       <= div_quo;
            latest_sample_reg <= sample_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average       = average_reg;
    assign latest_sample = latest_sample_reg;

    // An accepted sample always moves on to the ring read
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_READ))
        else $error("accepted sample did not start a ring read");

    // Head stays inside the window outside a restart
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_INIT) |-> (32'(head_reg) < 32'(eff_n)))
        else $error("head outside the window");

    // A write to a known register restarts the window
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_fire && (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_START_VALUE))
        |=> (state_reg == ST_INIT))
        else $error("configuration write did not restart the window");

    // A result appears only when the divider has finished
    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DIV && div_stat.done))
        else $error("result presented without a finished division");

    // The divider is idle whenever a new sample is taken
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !div_stat.busy)
        else $error("sample accepted while the divider was busy");

endmodule

// ===== hdl/mavg_ring.sv =====
module mavg_ring
    import mavg_pkg::*;
#(
    parameter int DEPTH = 255,
    parameter int AW    = 8
) (
    input  logic                clk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data
);

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/mavg_div.sv =====
module mavg_div
    import mavg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] num,
    input  logic [WIN_W-1:0]        den,
    output logic signed [AVG_W-1:0] quo,
    output div_stat_t               stat
);

    localparam int DIVD_W = SUM_W + FRAC_W;
    localparam int CNT_W  = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] shift_reg;
    logic [WIN_W-1:0]  rem_reg;
    logic [WIN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [SUM_W-1:0]  mag;
    logic [WIN_W:0]    trial;
    logic [WIN_W-1:0]  diff;
    logic              fits;
    logic [WIN_W-1:0]  rem_next;
    logic [AVG_W-1:0]  quo_mag;

    // Magnitude of the dividend; the result sign is applied at the end
    assign mag = num[SUM_W-1] ? (~num + SUM_W'(1)) : num;

    // One restoring step: shift in the next dividend bit, try to subtract
    assign trial    = {rem_reg, shift_reg[DIVD_W-1]};
    assign diff     = trial[WIN_W-1:0] - den_reg;
    assign fits     = (trial >= {1'b0, den_reg});
    assign rem_next = fits ? diff : trial[WIN_W-1:0];

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DIVD_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: dividend shifts out at the top while quotient bits enter below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= {mag, FRAC_W'(0)};
            rem_reg   <= '0;
            den_reg   <= den;
            neg_reg   <= num[SUM_W-1];
        end
        else if (cnt_reg != '0)
        begin
            shift_reg <= {shift_reg[DIVD_W-2:0], fits};
            rem_reg   <= rem_next;
        end
    end

    // Truncate toward zero: divide magnitudes, then restore the sign
    assign quo_mag = shift_reg[AVG_W-1:0];
    assign quo     = neg_reg ? $signed(~quo_mag + AVG_W'(1)) : $signed(quo_mag);

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

// ===== sim/tb_moving_average_filter_top.sv =====
module tb_moving_average_filter_top;
    import mavg_pkg::*;

    localparam int RING_DEPTH    = 255;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 45;
    localparam int TARGET_ITEMS  = 1700;

    // Indexes that decode to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic signed [AVG_W-1:0]    mean;
        logic signed [SAMPLE_W-1:0] newest;
    } mean_result_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  sample    = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [AVG_W-1:0]     average;
    logic signed [SAMPLE_W-1:0]  latest_sample;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = REG_WINDOW_SIZE;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;

    // Stimulus and scoreboard storage
    logic signed [SAMPLE_W-1:0]  samples_to_send [$];
    mean_result_t                expected_means [$];
    int                          failures      = 0;
    int                          quiet_cycles  = 0;
    int                          in_idle_pct   = 30;
    int                          out_idle_pct  = 30;
    int                          in_gap        = 0;
    int                          out_hold      = 0;
    int                          items_queued  = 0;

    // Shadow of the filter state
    logic [WIN_W-1:0]            win_setting;
    logic signed [SAMPLE_W-1:0]  start_setting;
    logic signed [SAMPLE_W-1:0]  ring_model [RING_DEPTH];
    int unsigned                 head_model;
    int                          sum_model;

    moving_average_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average       (average),
        .latest_sample (latest_sample),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Zero-length window behaves as a single sample
    function automatic int unsigned window_len();
        return (win_setting == 0) ? 1 : int'(win_setting);
    endfunction

    function automatic void restart_window();
        foreach (ring_model[i])
            ring_model[i] = start_setting;
        head_model = 0;
        sum_model  = int'(start_setting) * int'(window_len());
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        if (idx == REG_WINDOW_SIZE)
        begin
            win_setting = data[WIN_W-1:0];
            restart_window();
        end
        else if (idx == REG_START_VALUE)
        begin
            start_setting = data;
            restart_window();
        end
    endfunction

    // Replace the oldest entry and work out the new mean
    function automatic void advance_window(input logic signed [SAMPLE_W-1:0] s);
        int unsigned  n;
        int unsigned  pos;
        longint       scaled;
        mean_result_t r;
        n   = window_len();
        pos = head_model;
        if (pos >= n)
            pos = 0;
        sum_model = sum_model - int'(ring_model[pos]) + int'(s);
        ring_model[pos] = s;
        pos++;
        head_model = (pos >= n) ? 0 : pos;
        scaled   = (longint'(sum_model) * 256) / longint'(n);
        r.mean   = scaled[AVG_W-1:0];
        r.newest = s;
        expected_means.push_back(r);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Sample driver: hold each request until taken, idle at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= in_idle_pct)
            begin
                in_valid <= 1'b1;
                sample   <= samples_to_send.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                if (in_idle_pct > 0 && $urandom_range(0, 63) == 0)
                    in_gap <= $urandom_range(1, 40);
            end
        end
    end

    // Result receiver: stall at random, now and then for a long stretch
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (out_hold > 0)
        begin
            out_hold  <= out_hold - 1;
            out_ready <= 1'b0;
        end
        else if (out_idle_pct > 0 && $urandom_range(0, 511) == 0)
        begin
            out_hold  <= $urandom_range(1, 90);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
        end
    end

    // Monitor: check results against the oldest expectation, track state
    always @(posedge clk)
    begin
        mean_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    $error("unexpected result: average %0d, latest_sample %0d",
                           average, latest_sample);
                    failures++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (average !== want.mean)
                    begin
                        $error("average mismatch: expected %0d, actual %0d",
                               want.mean, average);
                        failures++;
                    end
                    if (latest_sample !== want.newest)
                    begin
                        $error("latest_sample mismatch: expected %0d, actual %0d",
                               want.newest, latest_sample);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
                advance_window(sample);
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("moving_average_filter_top verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(input logic signed [SAMPLE_W-1:0] s);
        samples_to_send.push_back(s);
        items_queued++;
    endtask

    // Wait until every request has been taken and answered, then settle
    task automatic drain();
        do
            @(posedge clk);
        while (samples_to_send.size() > 0 || in_valid || expected_means.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [WIN_W-1:0]      win;
        logic [CFG_DATA_W-1:0] data;
        int                    count;
        int                    phase;
        bit                    calm;

        win_setting   = 8'd16;
        start_setting = '0;
        restart_window();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: field extremes and alternating bit patterns
        send(16'sh7FFF);
        send(16'sh8000);
        send(16'sh0000);
        send(16'shFFFF);
        send(16'sh0001);
        send(16'sh5555);
        send(16'shAAAA);
        drain();

        // Unknown register index: window must carry on untouched
        write_reg(REG_SPARE_A, 16'h1234);
        send(16'sd100);
        send(-16'sd100);
        drain();

        // Single-sample window, upper data bits ignored
        write_reg(REG_WINDOW_SIZE, 16'hFF01);
        write_reg(REG_START_VALUE, 16'h8000);
        send(16'sh7FFF);
        send(16'sh8000);
        send(16'sh8000);
        drain();

        // Window of zero acts as one
        write_reg(REG_START_VALUE, 16'h7FFF);
        write_reg(REG_WINDOW_SIZE, 16'h0000);
        send(16'sd5);
        send(-16'sd5);
        drain();

        // Widest window at the largest and smallest sums
        write_reg(REG_WINDOW_SIZE, 16'h00FF);
        send(16'sh7FFF);
        send(16'sh7FFF);
        send(16'sh7FFF);
        send(16'sh8000);
        send(16'sh8000);
        drain();
        write_reg(REG_START_VALUE, 16'h8000);
        send(16'sh8000);
        send(16'sh8000);
        send(16'sh7FFF);
        drain();

        // Random phases; before each, the settings may be rewritten at random
        phase = 0;
        while (items_queued < TARGET_ITEMS)
        begin
            calm = (phase == 0) || ($urandom_range(0, 7) == 0);
            in_idle_pct  = calm ? 0 : 30;
            out_idle_pct = calm ? 0 : 30;

            case ($urandom_range(0, 9))
                0:       win = 8'd255;
                1:       win = 8'd0;
                2:       win = 8'd1;
                3, 4:    win = WIN_W'($urandom_range(2, 255));
                default: win = WIN_W'($urandom_range(2, 12));
            endcase
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                data = CFG_DATA_W'($urandom);
                data[WIN_W-1:0] = win;
                write_reg(REG_WINDOW_SIZE, data);
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       data = 16'h8000;
                    1:       data = 16'h7FFF;
                    2:       data = 16'h0000;
                    default: data = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_START_VALUE, data);
            end
            if ($urandom_range(0, 5) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom));

            if (win_setting > 12)
                count = $urandom_range(50, 320);
            else
                count = $urandom_range(10, 80);
            if (count > TARGET_ITEMS - items_queued)
                count = TARGET_ITEMS - items_queued;
            repeat (count) send(pick_sample());
            drain();
            phase++;
        end

        if (failures == 0)
            $display("moving_average_filter_top verification clean");
        else
            $display("moving_average_filter_top verification failed");
        $finish;
    end

endmodule
